// ===== src/lmbn_pkg.sv =====
package lmbn_pkg;

  // default geometry
  localparam int WINDOW_RADIUS_DEF = 10;
  localparam int TILE_SIZE_DEF     = 5;
  localparam int IMAGE_ROWS_DEF    = 256;
  localparam int IMAGE_COLS_DEF    = 256;

  localparam int GREY_W    = 8;
  localparam int COORD_W   = 8;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 2'd2;

  // register reset values
  localparam logic [GREY_W-1:0] TARGET_RST = 8'd64;
  localparam logic [GREY_W-1:0] MIN_RST    = 8'd0;
  localparam logic [GREY_W-1:0] MAX_RST    = 8'd255;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_PIX,
    S_SUM,
    S_DRAIN,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_FIN
  } state_t;

endpackage

// ===== src/local_mean_brightness_normalizer_core.sv =====
// channel  direction  handshake            payload
// in_      input      in_valid / in_stall  in_kind, in_row, in_col, in_pixel
// out_     output     out_valid / out_stall out_pixel, out_covered
// cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// a write transfer goes to the image store in the cycle it is taken; in_stall stays low
// a read steps to the tile centre, then reads the pixel and the window sum through the single
// store port, multiplies by the window area and the target level and divides at one quotient
// bit per cycle; uncovered reads skip to the result, a zero window sum skips the division
// no clearing pass: the store is undefined until written
// synchronous active-low reset; a finished result waits in the output register
// while out_stall is high and the next item can already be taken
module local_mean_brightness_normalizer_core #(
  parameter int WINDOW_RADIUS = lmbn_pkg::WINDOW_RADIUS_DEF,
  parameter int TILE_SIZE     = lmbn_pkg::TILE_SIZE_DEF,
  parameter int IMAGE_ROWS    = lmbn_pkg::IMAGE_ROWS_DEF,
  parameter int IMAGE_COLS    = lmbn_pkg::IMAGE_COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [lmbn_pkg::COORD_W-1:0]   in_row,
  input  logic [lmbn_pkg::COORD_W-1:0]   in_col,
  input  logic [lmbn_pkg::GREY_W-1:0]    in_pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lmbn_pkg::GREY_W-1:0]    out_pixel,
  output logic                           out_covered,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lmbn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmbn_pkg::GREY_W-1:0]    cfg_data
);

  localparam int HALF  = (TILE_SIZE - 1) / 2;
  localparam int SIDE  = 2 * WINDOW_RADIUS + 1;
  localparam int AREA  = SIDE * SIDE;
  localparam int DEPTH = IMAGE_ROWS * IMAGE_COLS;
  localparam int AW    = $clog2(DEPTH);
  // candidate centres run a little past the last coordinate
  localparam int CW    = $clog2(256 + TILE_SIZE + WINDOW_RADIUS + HALF + 1);
  localparam int SW    = $clog2(AREA * 255 + 1);
  localparam int PW    = $clog2(AREA * 255 + 1);
  localparam int NW    = $clog2(AREA * 255 * 255 + 1);
  localparam int DCW   = $clog2(NW);
  localparam int GW    = lmbn_pkg::GREY_W;

  lmbn_pkg::state_t state_r, state_nxt;

  logic [GW-1:0] target_r, min_r, max_r;

  logic [lmbn_pkg::COORD_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [CW-1:0] cr_r, cr_nxt, cc_r, cc_nxt;
  logic [CW-1:0] wrow_r, wrow_nxt, wcol_r, wcol_nxt;
  logic          cov_r, cov_nxt;
  logic          rd_pix_r, rd_pix_nxt, rd_sum_r, rd_sum_nxt;
  logic [GW-1:0] pix_r, pix_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;

  logic          out_valid_r;
  logic [GW-1:0] out_pixel_r, out_pixel_nxt;
  logic          out_covered_r, out_covered_nxt;
  logic          out_load;

  // store port
  logic                        mem_we;
  logic [AW-1:0]               mem_addr;
  logic [GW-1:0]               mem_rdata;
  logic [lmbn_pkg::COORD_W-1:0] addr_row, addr_col;

  // centre search and divider helpers
  logic          r_done, c_done;
  logic          r_hit, c_hit;
  logic [SW:0]   trial;
  logic          q_bit;
  logic [GW-1:0] clamp_hi;
  logic [GW-1:0] clamp_val;

  assign in_stall    = (state_r != lmbn_pkg::S_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_pixel   = out_pixel_r;
  assign out_covered = out_covered_r;

  // output slot is free when empty or being taken this cycle
  assign out_load = (state_r == lmbn_pkg::S_FIN) && (!out_valid_r || !out_stall);

  // address: the incoming item in idle, the read pixel once, then the window walk
  always_comb begin
    if (state_r == lmbn_pkg::S_IDLE) begin
      addr_row = in_row;
      addr_col = in_col;
    end else if (state_r == lmbn_pkg::S_PIX) begin
      addr_row = row_r;
      addr_col = col_r;
    end else begin
      addr_row = wrow_r[lmbn_pkg::COORD_W-1:0];
      addr_col = wcol_r[lmbn_pkg::COORD_W-1:0];
    end
  end

  assign mem_addr = AW'(addr_row) * AW'(IMAGE_COLS) + AW'(addr_col);

  // writes outside the image are dropped
  assign mem_we = (state_r == lmbn_pkg::S_IDLE) && in_valid && (in_kind == lmbn_pkg::KIND_WRITE)
                  && (32'(in_row) < IMAGE_ROWS) && (32'(in_col) < IMAGE_COLS);

  lmbn_ram #(
    .WIDTH (GW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_pixel),
    .rdata (mem_rdata)
  );

  // centre search: step each axis by one tile until the tile's far edge reaches the pixel
  assign r_done = (cr_r + CW'(HALF)) >= CW'(row_r);
  assign c_done = (cc_r + CW'(HALF)) >= CW'(col_r);
  // pixel inside that tile, and the window fits in the image
  assign r_hit  = (32'(row_r) < IMAGE_ROWS) && ((CW'(row_r) + CW'(HALF)) >= cr_r)
                  && (cr_r < CW'(IMAGE_ROWS - WINDOW_RADIUS));
  assign c_hit  = (32'(col_r) < IMAGE_COLS) && ((CW'(col_r) + CW'(HALF)) >= cc_r)
                  && (cc_r < CW'(IMAGE_COLS - WINDOW_RADIUS));

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r, num_r[NW-1]};
  assign q_bit = (trial >= {1'b0, sum_r});

  // clamp: a zero sum counts as unbounded, max first, min last
  always_comb begin
    if (sum_r == '0 || num_r > NW'(max_r)) begin
      clamp_hi = max_r;
    end else begin
      clamp_hi = num_r[GW-1:0];
    end
    if (clamp_hi < min_r) begin
      clamp_val = min_r;
    end else begin
      clamp_val = clamp_hi;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    row_nxt         = row_r;
    col_nxt         = col_r;
    cr_nxt          = cr_r;
    cc_nxt          = cc_r;
    wrow_nxt        = wrow_r;
    wcol_nxt        = wcol_r;
    cov_nxt         = cov_r;
    rd_pix_nxt      = 1'b0;
    rd_sum_nxt      = 1'b0;
    pix_nxt         = pix_r;
    sum_nxt         = sum_r;
    prod_nxt        = prod_r;
    num_nxt         = num_r;
    rem_nxt         = rem_r;
    dcnt_nxt        = dcnt_r;
    out_pixel_nxt   = out_pixel_r;
    out_covered_nxt = out_covered_r;

    // registered read data arrives in the cycle after its address
    if (rd_pix_r) begin
      pix_nxt = mem_rdata;
    end
    if (rd_sum_r) begin
      sum_nxt = sum_r + SW'(mem_rdata);
    end

    unique case (state_r)
      lmbn_pkg::S_IDLE: begin
        if (in_valid && in_kind == lmbn_pkg::KIND_READ) begin
          row_nxt   = in_row;
          col_nxt   = in_col;
          cr_nxt    = CW'(WINDOW_RADIUS);
          cc_nxt    = CW'(WINDOW_RADIUS);
          state_nxt = lmbn_pkg::S_FIND;
        end
      end
      lmbn_pkg::S_FIND: begin
        if (!r_done) begin
          cr_nxt = cr_r + CW'(TILE_SIZE);
        end
        if (!c_done) begin
          cc_nxt = cc_r + CW'(TILE_SIZE);
        end
        if (r_done && c_done) begin
          cov_nxt = r_hit && c_hit;
          if (r_hit && c_hit) begin
            state_nxt = lmbn_pkg::S_PIX;
          end else begin
            state_nxt = lmbn_pkg::S_FIN;
          end
        end
      end
      lmbn_pkg::S_PIX: begin
        rd_pix_nxt = 1'b1;
        sum_nxt    = '0;
        wrow_nxt   = cr_r - CW'(WINDOW_RADIUS);
        wcol_nxt   = cc_r - CW'(WINDOW_RADIUS);
        state_nxt  = lmbn_pkg::S_SUM;
      end
      lmbn_pkg::S_SUM: begin
        rd_sum_nxt = 1'b1;
        if (wcol_r == cc_r + CW'(WINDOW_RADIUS)) begin
          wcol_nxt = cc_r - CW'(WINDOW_RADIUS);
          if (wrow_r == cr_r + CW'(WINDOW_RADIUS)) begin
            state_nxt = lmbn_pkg::S_DRAIN;
          end else begin
            wrow_nxt = wrow_r + CW'(1);
          end
        end else begin
          wcol_nxt = wcol_r + CW'(1);
        end
      end
      lmbn_pkg::S_DRAIN: begin
        state_nxt = lmbn_pkg::S_MUL1;
      end
      lmbn_pkg::S_MUL1: begin
        prod_nxt  = PW'(pix_r) * PW'(AREA);
        state_nxt = lmbn_pkg::S_MUL2;
      end
      lmbn_pkg::S_MUL2: begin
        num_nxt  = NW'(prod_r) * NW'(target_r);
        rem_nxt  = '0;
        dcnt_nxt = DCW'(NW - 1);
        if (sum_r == '0) begin
          state_nxt = lmbn_pkg::S_FIN;
        end else begin
          state_nxt = lmbn_pkg::S_DIV;
        end
      end
      lmbn_pkg::S_DIV: begin
        if (q_bit) begin
          rem_nxt = SW'(trial - {1'b0, sum_r});
        end else begin
          rem_nxt = trial[SW-1:0];
        end
        num_nxt = {num_r[NW-2:0], q_bit};
        if (dcnt_r == '0) begin
          state_nxt = lmbn_pkg::S_FIN;
        end else begin
          dcnt_nxt = dcnt_r - DCW'(1);
        end
      end
      lmbn_pkg::S_FIN: begin
        if (out_load) begin
          out_covered_nxt = cov_r;
          out_pixel_nxt   = cov_r ? clamp_val : '0;
          state_nxt       = lmbn_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lmbn_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lmbn_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      rd_pix_r    <= 1'b0;
      rd_sum_r    <= 1'b0;
      target_r    <= lmbn_pkg::TARGET_RST;
      min_r       <= lmbn_pkg::MIN_RST;
      max_r       <= lmbn_pkg::MAX_RST;
    end else begin
      state_r  <= state_nxt;
      rd_pix_r <= rd_pix_nxt;
      rd_sum_r <= rd_sum_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lmbn_pkg::CFG_TARGET: target_r <= cfg_data;
          lmbn_pkg::CFG_MIN:    min_r    <= cfg_data;
          lmbn_pkg::CFG_MAX:    max_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    row_r         <= row_nxt;
    col_r         <= col_nxt;
    cr_r          <= cr_nxt;
    cc_r          <= cc_nxt;
    wrow_r        <= wrow_nxt;
    wcol_r        <= wcol_nxt;
    cov_r         <= cov_nxt;
    pix_r         <= pix_nxt;
    sum_r         <= sum_nxt;
    prod_r        <= prod_nxt;
    num_r         <= num_nxt;
    rem_r         <= rem_nxt;
    dcnt_r        <= dcnt_nxt;
    out_pixel_r   <= out_pixel_nxt;
    out_covered_r <= out_covered_nxt;
  end

endmodule

// ===== src/lmbn_ram.sv =====
module lmbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/lmbn_checker.sv =====
module lmbn_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           in_kind,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [lmbn_pkg::GREY_W-1:0]    out_pixel,
  input logic                           out_covered
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel) && $stable(out_covered))
    else $error("stalled result changed");

  // uncovered pixels read zero
  a_uncov_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_covered |-> out_pixel == '0)
    else $error("uncovered result is not zero");

  // a read transfer keeps the block busy
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == lmbn_pkg::KIND_READ |=> in_stall)
    else $error("read transfer did not start work");

  // a new result only comes out of a busy cycle
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work");

endmodule

bind local_mean_brightness_normalizer_core lmbn_checker u_lmbn_checker (.*);

// ===== tb/tb_local_mean_brightness_normalizer_core.sv =====
`timescale 1ns / 100ps

module tb_local_mean_brightness_normalizer_core;

  // geometry at the default parameters
  localparam int RADIUS    = lmbn_pkg::WINDOW_RADIUS_DEF;
  localparam int TILE      = lmbn_pkg::TILE_SIZE_DEF;
  localparam int ROWS      = lmbn_pkg::IMAGE_ROWS_DEF;
  localparam int COLS      = lmbn_pkg::IMAGE_COLS_DEF;
  localparam int HALF_TILE = (TILE - 1) / 2;
  localparam int WIN_AREA  = (2 * RADIUS + 1) * (2 * RADIUS + 1);

  typedef logic [lmbn_pkg::COORD_W-1:0]   coord_t;
  typedef logic [lmbn_pkg::GREY_W-1:0]    grey_t;
  typedef logic [lmbn_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  // index with no register behind it, writes there must be dropped
  localparam cfg_idx_t CFG_SPARE = 2'd3;

  // the one window that gets filled up front: top-left corner around centre 10
  // its tile covers rows and columns 8..12
  localparam int REGION_LO = 0;
  localparam int REGION_HI = 2 * RADIUS;
  localparam int TILE_LO   = RADIUS - HALF_TILE;
  localparam int TILE_HI   = RADIUS + HALF_TILE;

  localparam int HOLD_CYCLES   = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int MAX_PRINTED   = 50;

  typedef struct packed {
    grey_t grey;
    logic  covered;
  } norm_result_t;

  // clock, reset and dut ports; the driven ones are known from time zero
  logic     clk         = 1'b0;
  logic     rst_n       = 1'b0;
  logic     in_valid    = 1'b0;
  logic     in_stall;
  logic     in_kind     = lmbn_pkg::KIND_WRITE;
  coord_t   in_row      = '0;
  coord_t   in_col      = '0;
  grey_t    in_pixel    = '0;
  logic     out_valid;
  logic     out_stall   = 1'b0;
  grey_t    out_pixel;
  logic     out_covered;
  logic     cfg_valid   = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index   = '0;
  grey_t    cfg_data    = '0;

  // shadow of the block: image, which pixels hold data, registers
  grey_t image_mem [ROWS * COLS];
  bit    written_mem [ROWS * COLS];
  grey_t target_q = lmbn_pkg::TARGET_RST;
  grey_t min_q    = lmbn_pkg::MIN_RST;
  grey_t max_q    = lmbn_pkg::MAX_RST;

  // normalized pixels still owed by the block, oldest first
  norm_result_t pending_grey [$];
  norm_result_t want_res;

  int  mismatches  = 0;
  int  cycle_count = 0;
  int  burst_left  = 0;
  bit  sender_gaps = 1'b1;
  int  stall_mode  = 0;
  int  mode_left   = 0;
  bit  hold_busy   = 1'b0;
  event start_hold;

  local_mean_brightness_normalizer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_row      (in_row),
    .in_col      (in_col),
    .in_pixel    (in_pixel),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_pixel   (out_pixel),
    .out_covered (out_covered),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #10 clk = ~clk;

  // ------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------

  // tile centre along one axis that owns pos; 0 when pos lies in no tile
  // (border without a usable centre or centre whose window would overrun)
  function automatic bit tile_centre(input int pos, input int lim, output int centre);
    int t;
    int k;
    int off;
    if (pos < 0 || pos >= lim) return 1'b0;
    t = pos + HALF_TILE - RADIUS;
    if (t < 0) return 1'b0;
    k   = t / TILE;
    off = t - k * TILE;
    if (off > 2 * HALF_TILE) return 1'b0;
    centre = RADIUS + k * TILE;
    if (centre >= lim - RADIUS) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit window_ready(input int cr, input int cc);
    for (int i = -RADIUS; i <= RADIUS; i++)
      for (int j = -RADIUS; j <= RADIUS; j++)
        if (!written_mem[(cr + i) * COLS + cc + j]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic longint unsigned window_total(input int cr, input int cc);
    longint unsigned acc;
    acc = 0;
    for (int i = -RADIUS; i <= RADIUS; i++)
      for (int j = -RADIUS; j <= RADIUS; j++)
        acc += image_mem[(cr + i) * COLS + cc + j];
    return acc;
  endfunction

  // a read is legal when it is outside every tile or its whole window is written
  function automatic bit read_allowed(input int row, input int col);
    int cr;
    int cc;
    if (!tile_centre(row, ROWS, cr) || !tile_centre(col, COLS, cc)) return 1'b1;
    return window_ready(cr, cc);
  endfunction

  // expected answer to a read at (row, col) with the present image and registers
  function automatic norm_result_t normalize_pixel(input int row, input int col);
    norm_result_t    res;
    int              cr;
    int              cc;
    longint unsigned total;
    longint unsigned quo;
    longint unsigned p;
    res.grey    = '0;
    res.covered = 1'b0;
    if (!tile_centre(row, ROWS, cr) || !tile_centre(col, COLS, cc)) return res;
    total = window_total(cr, cc);
    p     = image_mem[row * COLS + col];
    // zero window sum counts as an unbounded quotient
    if (total == 0) begin
      quo = max_q;
    end else begin
      quo = p * WIN_AREA * target_q / total;
      if (quo > max_q) quo = max_q;
    end
    // lower clamp last, so it wins when it sits above the upper clamp
    if (quo < min_q) quo = min_q;
    res.grey    = quo[lmbn_pkg::GREY_W-1:0];
    res.covered = 1'b1;
    return res;
  endfunction

  // ------------------------------------------------------------------
  // checking
  // ------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED)
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // every result transfer is matched against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_grey.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: pixel %0d covered %0b",
                                  out_pixel, out_covered));
      end else begin
        want_res = pending_grey.pop_front();
        if (out_pixel !== want_res.grey)
          report_mismatch($sformatf("out_pixel %0d, expected %0d", out_pixel, want_res.grey));
        if (out_covered !== want_res.covered)
          report_mismatch($sformatf("out_covered %0b, expected %0b",
                                    out_covered, want_res.covered));
      end
    end
  end

  // run limit, far above the slowest correct run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // result side: stall pattern and long hold-off
  // ------------------------------------------------------------------

  // long hold-off, counted here; the receiver only looks at hold_busy
  always begin
    @(start_hold);
    hold_busy = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_busy = 1'b0;
  end

  // stall modes: never, coin flip, mostly stalled, fixed period
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_busy) begin
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(32, 600);
      end
      mode_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((cycle_count % 7) < 3);
      endcase
    end
  end

  // ------------------------------------------------------------------
  // input side
  // ------------------------------------------------------------------

  // one input transfer; bursts of random length with random gaps between
  task automatic send_pixel_op(input logic kind, input coord_t row, input coord_t col,
                               input grey_t pix);
    int gap;
    int idx;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (sender_gaps && $urandom_range(0, 9) >= 4) ? $urandom_range(1, 20) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_row   <= row;
    in_col   <= col;
    in_pixel <= pix;
    do @(posedge clk); while (in_stall !== 1'b0);
    // transfer taken at this edge: update the shadow in the same order
    idx = int'(row) * COLS + int'(col);
    if (kind == lmbn_pkg::KIND_WRITE) begin
      image_mem[idx]   = pix;
      written_mem[idx] = 1'b1;
    end else begin
      pending_grey.push_back(normalize_pixel(int'(row), int'(col)));
    end
  endtask

  task automatic write_pixel(input int row, input int col, input int value);
    send_pixel_op(lmbn_pkg::KIND_WRITE, coord_t'(row), coord_t'(col), grey_t'(value));
  endtask

  // the pixel field is ignored on reads, so it carries noise
  task automatic read_pixel(input int row, input int col);
    send_pixel_op(lmbn_pkg::KIND_READ, coord_t'(row), coord_t'(col),
                  grey_t'($urandom_range(0, 255)));
  endtask

  // block idle: nothing owed, then a short settle for the last pixel write
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_grey.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input grey_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      lmbn_pkg::CFG_TARGET: target_q = value;
      lmbn_pkg::CFG_MIN:    min_q    = value;
      lmbn_pkg::CFG_MAX:    max_q    = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_region_spot(output int row, output int col);
    row = $urandom_range(REGION_LO, REGION_HI);
    col = $urandom_range(REGION_LO, REGION_HI);
  endtask

  // read spot whose window is fully written, or one outside every tile
  task automatic pick_read_spot(output int row, output int col);
    int  sel;
    int  tries;
    bit  found;
    found = 1'b0;
    tries = 0;
    while (!found && tries < 200) begin
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        row = $urandom_range(TILE_LO, TILE_HI);
        col = $urandom_range(TILE_LO, TILE_HI);
      end else begin
        row = $urandom_range(0, 255);
        col = $urandom_range(0, 255);
      end
      found = read_allowed(row, col);
      tries++;
    end
    if (!found) begin
      row = 0;
      col = 0;
    end
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // the whole window starts at zero; later writes brighten it
  task automatic test_fill_image();
    for (int r = REGION_LO; r <= REGION_HI; r++)
      for (int c = REGION_LO; c <= REGION_HI; c++)
        write_pixel(r, c, 0);
  endtask

  // image corners, border rows and columns with no usable centre
  task automatic test_uncovered_reads();
    read_pixel(0, 0);
    read_pixel(255, 255);
    read_pixel(0, 255);
    read_pixel(7, 20);
    read_pixel(20, 7);
    read_pixel(248, 240);
    read_pixel(240, 248);
  endtask

  // first, last and centre pixels of the tile while the window sum is zero
  task automatic test_tile_edges();
    read_pixel(8, 8);
    read_pixel(12, 12);
    read_pixel(10, 10);
    read_pixel(8, 12);
    read_pixel(12, 8);
  endtask

  task automatic test_clamps_and_registers();
    // two bright pixels in an otherwise dark window: upper clamp and zero pixel
    write_pixel(10, 10, 255);
    write_pixel(20, 20, 255);
    read_pixel(10, 10);
    read_pixel(11, 11);
    read_pixel(12, 12);
    drain_results();
    // lower clamp above upper clamp: lower clamp wins
    write_register(lmbn_pkg::CFG_MIN, 8'd200);
    write_register(lmbn_pkg::CFG_MAX, 8'd100);
    read_pixel(11, 11);
    read_pixel(10, 10);
    drain_results();
    // zero target level gives a zero quotient
    write_register(lmbn_pkg::CFG_TARGET, 8'd0);
    write_register(lmbn_pkg::CFG_MIN, 8'd0);
    write_register(lmbn_pkg::CFG_MAX, 8'd255);
    read_pixel(10, 10);
    drain_results();
    // write to the unused index must leave the registers alone
    write_register(CFG_SPARE, 8'hA5);
    read_pixel(10, 10);
    // zero sum still gives max with a zero target
    write_pixel(10, 10, 0);
    write_pixel(20, 20, 0);
    read_pixel(9, 9);
  endtask

  // mostly legal reads, pixel rewrites in the filled window, stray writes anywhere
  task automatic test_random_traffic(input int count, input grey_t tgt,
                                     input grey_t lo, input grey_t hi);
    int sel;
    int row;
    int col;
    drain_results();
    write_register(lmbn_pkg::CFG_TARGET, tgt);
    write_register(lmbn_pkg::CFG_MIN, lo);
    write_register(lmbn_pkg::CFG_MAX, hi);
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        pick_read_spot(row, col);
        read_pixel(row, col);
      end else if (sel < 90) begin
        pick_region_spot(row, col);
        write_pixel(row, col, $urandom_range(0, 255));
      end else begin
        write_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      end
    end
  endtask

  // receiver holds off long enough that the output register and the
  // next result fill up and the block must stall its input
  task automatic test_backpressure();
    int row;
    int col;
    drain_results();
    write_register(lmbn_pkg::CFG_TARGET, grey_t'($urandom_range(1, 255)));
    write_register(lmbn_pkg::CFG_MIN, grey_t'($urandom_range(0, 60)));
    write_register(lmbn_pkg::CFG_MAX, grey_t'($urandom_range(180, 255)));
    sender_gaps = 1'b0;
    -> start_hold;
    repeat (8) begin
      pick_read_spot(row, col);
      read_pixel(row, col);
    end
    sender_gaps = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_fill_image();
    test_uncovered_reads();
    test_tile_edges();
    test_clamps_and_registers();

    // reset settings, full-range target, smallest target, crossed clamps, random
    test_random_traffic(16, lmbn_pkg::TARGET_RST, lmbn_pkg::MIN_RST, lmbn_pkg::MAX_RST);
    test_random_traffic(16, 8'd255, 8'd0, 8'd255);
    test_random_traffic(16, 8'd1, 8'd0, 8'd255);
    test_random_traffic(8, 8'd200, 8'd255, 8'd0);
    test_random_traffic(16, grey_t'($urandom_range(1, 255)), grey_t'($urandom_range(0, 255)),
                        grey_t'($urandom_range(0, 255)));
    test_backpressure();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_grey.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_grey.size()));
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lmbn_pkg.sv
src/lmbn_ram.sv
src/local_mean_brightness_normalizer_core.sv
src/lmbn_checker.sv
tb/tb_local_mean_brightness_normalizer_core.sv
